FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

FILE: rtl/core/rbf_pkg.sv
`default_nettype none

package rbf_pkg;

	localparam int STATE_FRAC      = 16;
	localparam int OUT_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 32;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_HP_COEF    = 2'd0,
		CFG_LP_COEF    = 2'd1,
		CFG_HP_ONLY    = 2'd2,
		CFG_SNAP_INDEX = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPERAND,
		ST_MULTIPLY,
		ST_WRITEBACK,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		STG_HP1,
		STG_HP2,
		STG_LP1,
		STG_LP2
	} stage_t;

	typedef struct packed {
		logic   idle;
		logic   op_load;
		logic   mul_load;
		logic   wb_load;
		logic   finish;
		stage_t stage;
	} ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbf_if.sv
`default_nettype none

interface rbf_sample_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_value;
	logic                           block_first;
	logic                           block_last;

	modport source (output valid, output sample_value, output block_first,
		output block_last, input ready);
	modport sink (input valid, input sample_value, input block_first,
		input block_last, output ready);
endinterface

interface rbf_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [rbf_pkg::OUT_WIDTH-1:0]    filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink (input valid, input filtered_value, output ready);
endinterface

interface rbf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [rbf_pkg::CFG_INDEX_WIDTH-1:0] index;
	logic [rbf_pkg::CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rbf_mul.sv
`default_nettype none

// Shared coefficient multiplier: registered product, rounded half up on read.
module rbf_mul #(
	parameter int COEF_W = 18,
	parameter int OP_W   = 41
) (
	input  wire logic                     clk,
	input  wire logic                     load,
	input  wire logic        [COEF_W-1:0] coef,
	input  wire logic signed [OP_W-1:0]   operand,
	output logic signed      [OP_W-1:0]   result
);

	localparam int PW = COEF_W + OP_W + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (COEF_W - 1);

	logic signed [PW-1:0] prod_d;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] rsum;

	assign prod_d = $signed({1'b0, coef}) * operand;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod_d;
		end
	end

	// Coefficient is below one, so the rounded value fits the operand width.
	assign rsum   = prod_q + HALF;
	assign result = rsum[COEF_W +: OP_W];

endmodule

`default_nettype wire

FILE: rtl/core/rbf_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module rbf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           hp_only,
	input  wire logic           out_free,
	output rbf_pkg::ctrl_t      ctrl
);

	rbf_pkg::state_t state_q, state_d;
	rbf_pkg::stage_t stage_q, stage_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbf_pkg::ST_IDLE;
			stage_q <= rbf_pkg::STG_HP1;
		end else begin
			state_q <= state_d;
			stage_q <= stage_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		stage_d       = stage_q;
		ctrl          = '0;
		ctrl.stage    = stage_q;
		case (state_q)
			rbf_pkg::ST_IDLE: begin
				ctrl.idle = 1'b1;
				if (in_fire) begin
					state_d = rbf_pkg::ST_OPERAND;
					stage_d = rbf_pkg::STG_HP1;
				end
			end
			rbf_pkg::ST_OPERAND: begin
				ctrl.op_load = 1'b1;
				state_d      = rbf_pkg::ST_MULTIPLY;
			end
			rbf_pkg::ST_MULTIPLY: begin
				ctrl.mul_load = 1'b1;
				state_d       = rbf_pkg::ST_WRITEBACK;
			end
			rbf_pkg::ST_WRITEBACK: begin
				ctrl.wb_load = 1'b1;
				state_d      = rbf_pkg::ST_OPERAND;
				case (stage_q)
					rbf_pkg::STG_HP1: stage_d = rbf_pkg::STG_HP2;
					rbf_pkg::STG_HP2: begin
						// skip the low-pass pair in high-pass-only mode
						if (hp_only) begin
							state_d = rbf_pkg::ST_FINISH;
						end else begin
							stage_d = rbf_pkg::STG_LP1;
						end
					end
					rbf_pkg::STG_LP1: stage_d = rbf_pkg::STG_LP2;
					default:          state_d = rbf_pkg::ST_FINISH;
				endcase
			end
			rbf_pkg::ST_FINISH: begin
				// hold until the output register can take the word
				if (out_free) begin
					ctrl.finish = 1'b1;
					state_d     = rbf_pkg::ST_IDLE;
				end
			end
			default: state_d = rbf_pkg::ST_IDLE;
		endcase
	end

	`ASSERT_CLK(a_accept_starts_hp1, clk, arst_n,
		in_fire |=> (state_q == rbf_pkg::ST_OPERAND && stage_q == rbf_pkg::STG_HP1))
	`ASSERT_CLK(a_operand_then_mul, clk, arst_n,
		(state_q == rbf_pkg::ST_OPERAND) |=> (state_q == rbf_pkg::ST_MULTIPLY))
	`ASSERT_CLK(a_finish_to_idle, clk, arst_n,
		ctrl.finish |=> (state_q == rbf_pkg::ST_IDLE))

endmodule

`default_nettype wire

FILE: rtl/core/recursive_bandpass_filter.sv
// Sequencing: for each accepted sample, the high-pass pair and then the low-pass
// pair (high-pass pair only in high-pass-only mode) each take operand, multiply
// and writeback steps on the single shared multiplier; a finish state then waits
// for the output register to be free. A new sample is accepted only when idle.
// Reset: asynchronous, clears filter state, saved state, block position,
// configuration registers and output valid; snapshot index resets to all ones.
`default_nettype none

`include "assert_macros.svh"

module recursive_bandpass_filter #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int STATE_WIDTH    = 40,
	parameter int COEF_FRAC_BITS = 18,
	parameter int INDEX_WIDTH    = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	rbf_sample_if.sink   in_ch,
	rbf_result_if.source out_ch,
	rbf_cfg_if.sink      cfg_ch
);

	localparam int S     = STATE_WIDTH;
	localparam int OP_W  = S + 1;
	localparam int SUM_W = (S + 2 > SAMPLE_WIDTH + 18) ? S + 2 : SAMPLE_WIDTH + 18;
	localparam int OW    = rbf_pkg::OUT_WIDTH;

	localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-S+1){1'b0}}, {(S-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SMIN = {{(SUM_W-S+1){1'b1}}, {(S-1){1'b0}}};
	localparam logic signed [S:0] OUT_HALF = (S+1)'(1) << (rbf_pkg::STATE_FRAC - 1);
	localparam logic signed [S:0] YMAX = {{(S+1-OW){1'b0}}, 1'b0, {(OW-1){1'b1}}};
	localparam logic signed [S:0] YMIN = {{(S+1-OW){1'b1}}, 1'b1, {(OW-1){1'b0}}};

	function automatic logic signed [S-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		logic signed [S-1:0] r;
		if (v > SMAX) begin
			r = SMAX[S-1:0];
		end else if (v < SMIN) begin
			r = SMIN[S-1:0];
		end else begin
			r = v[S-1:0];
		end
		return r;
	endfunction

	rbf_pkg::ctrl_t ctrl;

	logic [COEF_FRAC_BITS-1:0] hp_coef_q, lp_coef_q, coef_sel;
	logic                      hp_only_q;
	logic [INDEX_WIDTH-1:0]    snap_idx_q, pos_q;
	logic                      snap_done_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q, prev_q, saved_prev_q;
	logic                           last_q;
	logic signed [S-1:0] h1_q, h2_q, l1_q, l2_q, h1_old_q;
	logic signed [S-1:0] saved_h1_q, saved_h2_q, saved_l1_q, saved_l2_q;

	logic signed [OP_W-1:0]  op_d, op_q, mul_res;
	logic signed [SAMPLE_WIDTH:0] diff;
	logic signed [SUM_W-1:0] d_ext;
	logic signed [S-1:0]     lp_new;
	logic signed [S-1:0]     out_sel;
	logic signed [S:0]       ysum, yshift;
	logic signed [OW-1:0]    y;

	logic in_fire, out_free, snap_take;
	logic                 out_valid_q;
	logic signed [OW-1:0] out_data_q;

	assign in_ch.ready  = ctrl.idle;
	assign in_fire      = in_ch.valid & ctrl.idle;
	assign out_free     = !out_valid_q || out_ch.ready;
	assign cfg_ch.ready = 1'b1;

	rbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.hp_only  (hp_only_q),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	rbf_mul #(
		.COEF_W (COEF_FRAC_BITS),
		.OP_W   (OP_W)
	) u_mul (
		.clk     (clk),
		.load    (ctrl.mul_load),
		.coef    (coef_sel),
		.operand (op_q),
		.result  (mul_res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_coef_q  <= '0;
			lp_coef_q  <= '0;
			hp_only_q  <= 1'b0;
			snap_idx_q <= '1;
		end else if (cfg_ch.valid) begin
			case (rbf_pkg::cfg_index_t'(cfg_ch.index))
				rbf_pkg::CFG_HP_COEF:    hp_coef_q  <= cfg_ch.data[COEF_FRAC_BITS-1:0];
				rbf_pkg::CFG_LP_COEF:    lp_coef_q  <= cfg_ch.data[COEF_FRAC_BITS-1:0];
				rbf_pkg::CFG_HP_ONLY:    hp_only_q  <= cfg_ch.data[0];
				rbf_pkg::CFG_SNAP_INDEX: snap_idx_q <= cfg_ch.data[INDEX_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign coef_sel = (ctrl.stage == rbf_pkg::STG_HP1 || ctrl.stage == rbf_pkg::STG_HP2)
		? hp_coef_q : lp_coef_q;

	// Operand for the current stage
	assign diff  = (SAMPLE_WIDTH+1)'(x_q) - (SAMPLE_WIDTH+1)'(prev_q);
	assign d_ext = SUM_W'(diff) <<< rbf_pkg::STATE_FRAC;

	always_comb begin
		case (ctrl.stage)
			rbf_pkg::STG_HP1: op_d = OP_W'(sat_state(SUM_W'(h1_q) + d_ext));
			rbf_pkg::STG_HP2: op_d = OP_W'(sat_state(SUM_W'(h2_q) + SUM_W'(h1_q)
				- SUM_W'(h1_old_q)));
			rbf_pkg::STG_LP1: op_d = OP_W'(h2_q) - OP_W'(l1_q);
			default:          op_d = OP_W'(l1_q) - OP_W'(l2_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= in_ch.sample_value;
			last_q <= in_ch.block_last;
		end
		if (ctrl.op_load) begin
			op_q <= op_d;
			if (ctrl.stage == rbf_pkg::STG_HP1) begin
				h1_old_q <= h1_q;
			end
		end
	end

	assign lp_new = (ctrl.stage == rbf_pkg::STG_LP1)
		? sat_state(SUM_W'(l1_q) + SUM_W'(mul_res))
		: sat_state(SUM_W'(l2_q) + SUM_W'(mul_res));

	// Output rounding and saturation
	assign out_sel = hp_only_q ? h2_q : l2_q;
	assign ysum    = (S+1)'(out_sel) + OUT_HALF;
	assign yshift  = ysum >>> rbf_pkg::STATE_FRAC;
	always_comb begin
		if (yshift > YMAX) begin
			y = YMAX[OW-1:0];
		end else if (yshift < YMIN) begin
			y = YMIN[OW-1:0];
		end else begin
			y = yshift[OW-1:0];
		end
	end

	assign snap_take = !snap_done_q && (pos_q == snap_idx_q || last_q);

	// Filter state, saved state and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q         <= '0;
			h2_q         <= '0;
			l1_q         <= '0;
			l2_q         <= '0;
			prev_q       <= '0;
			saved_h1_q   <= '0;
			saved_h2_q   <= '0;
			saved_l1_q   <= '0;
			saved_l2_q   <= '0;
			saved_prev_q <= '0;
			pos_q        <= '0;
			snap_done_q  <= 1'b0;
		end else begin
			if (in_fire && in_ch.block_first) begin
				// reload working state from the saved copy
				h1_q        <= saved_h1_q;
				h2_q        <= saved_h2_q;
				if (!hp_only_q) begin
					l1_q <= saved_l1_q;
					l2_q <= saved_l2_q;
				end
				prev_q      <= saved_prev_q;
				pos_q       <= '0;
				snap_done_q <= 1'b0;
			end
			if (ctrl.wb_load) begin
				case (ctrl.stage)
					rbf_pkg::STG_HP1: h1_q <= mul_res[S-1:0];
					rbf_pkg::STG_HP2: h2_q <= mul_res[S-1:0];
					rbf_pkg::STG_LP1: l1_q <= lp_new;
					default:          l2_q <= lp_new;
				endcase
			end
			if (ctrl.finish) begin
				prev_q <= x_q;
				if (snap_take) begin
					saved_h1_q   <= h1_q;
					saved_h2_q   <= h2_q;
					if (!hp_only_q) begin
						saved_l1_q <= l1_q;
						saved_l2_q <= l2_q;
					end
					saved_prev_q <= x_q;
				end
				if (last_q) begin
					pos_q       <= '0;
					snap_done_q <= 1'b0;
				end else begin
					if (snap_take) begin
						snap_done_q <= 1'b1;
					end
					if (pos_q != '1) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_data_q <= y;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.filtered_value = out_data_q;

	`ASSERT_CLK(a_finish_loads_out, clk, arst_n, ctrl.finish |=> out_valid_q)
	`ASSERT_CLK(a_first_restarts_block, clk, arst_n,
		(in_fire && in_ch.block_first) |=> (pos_q == '0 && !snap_done_q))

endmodule

`default_nettype wire
